/* hw/rtl/obac_pkg.sv */
// shared constants, codes and types of the order book add/cancel core
package obac_pkg;

  localparam int MAX_ORDERS   = 4096;
  localparam int PRICE_LEVELS = 4096;
  localparam int PROBE_LIMIT  = 16;

  localparam int SLOT_W    = $clog2(MAX_ORDERS);
  localparam int OFF_W     = $clog2(PRICE_LEVELS);
  localparam int LVL_W     = OFF_W + 1;
  localparam int LEVELS    = 2 * PRICE_LEVELS;
  localparam int CLR_DEPTH = (LEVELS > MAX_ORDERS) ? LEVELS : MAX_ORDERS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int PCNT_W    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  localparam int ID_W     = 64;
  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 32;
  localparam int CNT_W    = 13;
  localparam int SUM_W    = 44;
  localparam int STATUS_W = 3;

  // hash keeps only the product bits that reach the slot index
  localparam int HASH_W = 32 + SLOT_W;
  localparam int HALF_W = HASH_W / 2;
  localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_FREED = 2'd2
  } slot_st_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_CANCELLED = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_RANGE     = 3'd5
  } result_st_t;

  typedef enum logic [1:0] {
    MODE_INS  = 2'd0,
    MODE_FILL = 2'd1,
    MODE_REM  = 2'd2
  } lvl_mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_PROBE,
    S_CHECK,
    S_LVL_RD,
    S_LVL_UPD,
    S_FRONT_RD,
    S_FRONT,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    slot_st_t              st;
    logic [ID_W-1:0]       key;
    logic [QTY_W-1:0]      qty;
    logic                  side;
    logic [OFF_W-1:0]      off;
  } slot_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W-1:0]  sum;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
  } level_word_t;

  typedef struct packed {
    logic       accept;
    logic       clr_step;
    logic       ld_home;
    logic       advance;
    logic       note_free;
    logic       take_free;
    logic       found;
    logic       set_st;
    result_st_t st;
    logic       lvl_upd;
    lvl_mode_t  mode;
    logic       rd_front;
    logic       ld_front;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind;
    logic oor;
    logic used;
    logic empty;
    logic key_match;
    logic probe_last;
    logic have_free;
    logic new_cnt_nz;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/obac_in_if.sv */
// order message channel: kind, id, price, side, quantity
interface obac_in_if;
  import obac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ID_W-1:0]      order_id;
  logic [PRICE_W-1:0]   price;
  logic                 side;
  logic [QTY_W-1:0]     quantity;

  modport source (output valid, kind, order_id, price, side, quantity, input ready);
  modport sink (input valid, kind, order_id, price, side, quantity, output ready);
endinterface

/* hw/rtl/obac_out_if.sv */
// result channel: status, order echo and level summary
interface obac_out_if;
  import obac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      result_id;
  logic [PRICE_W-1:0]   result_price;
  logic                 result_side;
  logic [QTY_W-1:0]     result_quantity;
  logic [CNT_W-1:0]     level_orders;
  logic [SUM_W-1:0]     level_total;
  logic [ID_W-1:0]      front_id;

  modport source (output valid, status, result_id, result_price, result_side,
                  result_quantity, level_orders, level_total, front_id, input ready);
  modport sink (input valid, status, result_id, result_price, result_side,
                result_quantity, level_orders, level_total, front_id, output ready);
endinterface

/* hw/rtl/obac_ram.sv */
// generic single write port ram with registered read
module obac_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/obac_ctrl.sv */
// sequencing state machine for probe, link update and result hand-off
module obac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  obac_pkg::dp_stat_t stat,
  output obac_pkg::dp_cmd_t  cmd
);
  import obac_pkg::*;

  ctrl_state_t state_r, state_nxt;
  lvl_mode_t   mode_r, mode_nxt;
  logic        any_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mode_r  <= MODE_FILL;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign any_free = stat.have_free || !stat.used;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    mode_nxt  = mode_r;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_HASH1;
        end
      end
      S_HASH1: begin
        state_nxt = S_HASH2;
      end
      S_HASH2: begin
        cmd.ld_home = 1'b1;
        if (!stat.kind && stat.oor) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.kind) begin
          if (stat.used && stat.key_match) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_DUPLICATE;
            mode_nxt   = MODE_FILL;
            state_nxt  = S_LVL_RD;
          end else if (stat.empty || stat.probe_last) begin
            cmd.set_st = 1'b1;
            state_nxt  = S_LVL_RD;
            if (any_free) begin
              cmd.take_free = 1'b1;
              cmd.st        = ST_ADDED;
              mode_nxt      = MODE_INS;
            end else begin
              cmd.st   = ST_FULL;
              mode_nxt = MODE_FILL;
            end
          end else begin
            cmd.note_free = 1'b1;
            cmd.advance   = 1'b1;
            state_nxt     = S_PROBE;
          end
        end else begin
          if (stat.empty) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_UNKNOWN;
            state_nxt  = S_DONE;
          end else if (stat.used && stat.key_match) begin
            cmd.found  = 1'b1;
            cmd.set_st = 1'b1;
            cmd.st     = ST_CANCELLED;
            mode_nxt   = MODE_REM;
            state_nxt  = S_LVL_RD;
          end else if (stat.probe_last) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_UNKNOWN;
            state_nxt  = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_PROBE;
          end
        end
      end
      S_LVL_RD: begin
        state_nxt = S_LVL_UPD;
      end
      S_LVL_UPD: begin
        cmd.lvl_upd = 1'b1;
        cmd.mode    = mode_r;
        state_nxt   = stat.new_cnt_nz ? S_FRONT_RD : S_DONE;
      end
      S_FRONT_RD: begin
        cmd.rd_front = 1'b1;
        state_nxt    = S_FRONT;
      end
      S_FRONT: begin
        cmd.ld_front = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

/* hw/rtl/obac_dp.sv */
// datapath: hash, directory and level memories, link updates, result register
module obac_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  obac_pkg::dp_cmd_t             cmd,
  output obac_pkg::dp_stat_t            stat,
  input  logic                          in_kind,
  input  logic [obac_pkg::ID_W-1:0]     in_order_id,
  input  logic [obac_pkg::PRICE_W-1:0]  in_price,
  input  logic                          in_side,
  input  logic [obac_pkg::QTY_W-1:0]    in_quantity,
  input  logic                          cfg_we,
  input  logic [obac_pkg::PRICE_W-1:0]  cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [obac_pkg::STATUS_W-1:0] out_status,
  output logic [obac_pkg::ID_W-1:0]     out_result_id,
  output logic [obac_pkg::PRICE_W-1:0]  out_result_price,
  output logic                          out_result_side,
  output logic [obac_pkg::QTY_W-1:0]    out_result_quantity,
  output logic [obac_pkg::CNT_W-1:0]    out_level_orders,
  output logic [obac_pkg::SUM_W-1:0]    out_level_total,
  output logic [obac_pkg::ID_W-1:0]     out_front_id
);
  import obac_pkg::*;

  localparam logic [HALF_W-1:0] B_LO = GOLDEN[HALF_W-1:0];
  localparam logic [HALF_W-1:0] B_HI = GOLDEN[HASH_W-1:HALF_W];

  logic [PRICE_W-1:0] base_r;
  logic               kind_r;
  logic [ID_W-1:0]    id_r;
  logic [PRICE_W-1:0] price_r;
  logic               side_r;
  logic [QTY_W-1:0]   qty_r;
  logic [OFF_W-1:0]   off_r;
  logic [HASH_W-1:0]  prod0_r;
  logic [HALF_W-1:0]  prod1_r, prod2_r;
  logic [SLOT_W-1:0]  ptr_r, free_r, tgt_r, front_slot_r;
  logic [PCNT_W-1:0]  pcnt_r;
  logic               have_free_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [CLR_W-1:0]   clr_r;
  result_st_t         st_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic [ID_W-1:0]    front_r;
  logic               out_valid_r;
  logic [STATUS_W-1:0] o_status_r;
  logic [ID_W-1:0]    o_id_r, o_front_r;
  logic [PRICE_W-1:0] o_price_r;
  logic               o_side_r;
  logic [QTY_W-1:0]   o_qty_r;
  logic [CNT_W-1:0]   o_cnt_r;
  logic [SUM_W-1:0]   o_sum_r;

  logic [HASH_W-1:0]  m1, m2, hash;
  logic [HALF_W-1:0]  mid;
  logic [SLOT_W-1:0]  home;
  logic [PRICE_W:0]   diff;

  slot_word_t  slot_q, slot_wd;
  level_word_t lvl_q, lvl_wd;
  logic [$bits(slot_word_t)-1:0]  slot_rdata;
  logic [$bits(level_word_t)-1:0] lvl_rdata;
  logic        slot_we, lvl_we;
  logic [SLOT_W-1:0] slot_waddr, slot_raddr;
  logic [LVL_W-1:0]  lvl_waddr;
  logic [SLOT_W-1:0] prv_q, nxt_q;

  logic [CNT_W-1:0]  new_cnt;
  logic [SUM_W-1:0]  new_sum;
  logic [SLOT_W-1:0] new_head, new_tail;
  logic              pv_we, nx_we;
  logic [SLOT_W-1:0] pv_addr, pv_data, nx_addr, nx_data;

  // hash: low product bits from three half-width multiplies, then fold
  assign m1   = id_r[HASH_W-1:HALF_W] * B_LO;
  assign m2   = id_r[HALF_W-1:0] * B_HI;
  assign mid  = prod1_r + prod2_r;
  assign hash = prod0_r + {mid, {HALF_W{1'b0}}};
  assign home = hash[SLOT_W-1:0] ^ hash[HASH_W-1:32];

  assign diff = {1'b0, price_r} - {1'b0, base_r};

  assign slot_q = slot_rdata;
  assign lvl_q  = lvl_rdata;

  always_ff @(posedge clk) begin
    prod0_r <= id_r[HALF_W-1:0] * B_LO;
    prod1_r <= m1[HALF_W-1:0];
    prod2_r <= m2[HALF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_kind;
      id_r    <= in_order_id;
      price_r <= in_kind ? '0 : in_price;
      side_r  <= in_kind ? 1'b0 : in_side;
      qty_r   <= in_kind ? '0 : in_quantity;
      cnt_r   <= '0;
      sum_r   <= '0;
      front_r <= '0;
    end
    if (cmd.ld_home) begin
      ptr_r       <= home;
      pcnt_r      <= '0;
      have_free_r <= 1'b0;
      off_r       <= diff[OFF_W-1:0];
      lvl_r       <= {side_r, diff[OFF_W-1:0]};
    end
    if (cmd.advance) begin
      ptr_r  <= ptr_r + SLOT_W'(1);
      pcnt_r <= pcnt_r + PCNT_W'(1);
    end
    if (cmd.note_free && !have_free_r && (slot_q.st != SLOT_USED)) begin
      free_r      <= ptr_r;
      have_free_r <= 1'b1;
    end
    if (cmd.take_free) begin
      tgt_r <= have_free_r ? free_r : ptr_r;
    end
    if (cmd.found) begin
      tgt_r   <= ptr_r;
      qty_r   <= slot_q.qty;
      side_r  <= slot_q.side;
      off_r   <= slot_q.off;
      lvl_r   <= {slot_q.side, slot_q.off};
      price_r <= base_r + PRICE_W'(slot_q.off);
    end
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
    if (cmd.lvl_upd) begin
      cnt_r        <= new_cnt;
      sum_r        <= new_sum;
      front_slot_r <= new_head;
      front_r      <= '0;
    end
    if (cmd.ld_front) begin
      front_r <= slot_q.key;
    end
    if (cmd.load_out) begin
      o_status_r <= st_r;
      o_id_r     <= id_r;
      o_price_r  <= price_r;
      o_side_r   <= side_r;
      o_qty_r    <= qty_r;
      o_cnt_r    <= cnt_r;
      o_sum_r    <= sum_r;
      o_front_r  <= front_r;
    end
  end

  // level update and neighbour relinking
  always_comb begin
    new_cnt  = lvl_q.cnt;
    new_sum  = lvl_q.sum;
    new_head = lvl_q.head;
    new_tail = lvl_q.tail;
    pv_we    = 1'b0;
    pv_addr  = tgt_r;
    pv_data  = tgt_r;
    nx_we    = 1'b0;
    nx_addr  = lvl_q.tail;
    nx_data  = tgt_r;
    case (cmd.mode)
      MODE_INS: begin
        new_cnt  = lvl_q.cnt + CNT_W'(1);
        new_sum  = lvl_q.sum + SUM_W'(qty_r);
        new_tail = tgt_r;
        pv_we    = cmd.lvl_upd;
        if (lvl_q.cnt == '0) begin
          new_head = tgt_r;
        end else begin
          pv_data = lvl_q.tail;
          nx_we   = cmd.lvl_upd;
        end
      end
      MODE_REM: begin
        new_cnt = (lvl_q.cnt != '0) ? lvl_q.cnt - CNT_W'(1) : lvl_q.cnt;
        new_sum = (lvl_q.sum >= SUM_W'(qty_r)) ? lvl_q.sum - SUM_W'(qty_r) : '0;
        if (lvl_q.cnt > CNT_W'(1)) begin
          if (tgt_r == lvl_q.head) begin
            new_head = nxt_q;
          end else begin
            nx_we   = cmd.lvl_upd;
            nx_addr = prv_q;
            nx_data = nxt_q;
          end
          if (tgt_r == lvl_q.tail) begin
            new_tail = prv_q;
          end else begin
            pv_we   = cmd.lvl_upd;
            pv_addr = nxt_q;
            pv_data = prv_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    slot_wd     = '0;
    slot_wd.st  = SLOT_EMPTY;
    lvl_wd      = '0;
    slot_waddr  = clr_r[SLOT_W-1:0];
    lvl_waddr   = clr_r[LVL_W-1:0];
    slot_we     = cmd.clr_step && (int'(clr_r) < MAX_ORDERS);
    lvl_we      = cmd.clr_step && (int'(clr_r) < LEVELS);
    if (!cmd.clr_step) begin
      slot_waddr   = tgt_r;
      lvl_waddr    = lvl_r;
      slot_wd.st   = (cmd.mode == MODE_INS) ? SLOT_USED : SLOT_FREED;
      slot_wd.key  = id_r;
      slot_wd.qty  = qty_r;
      slot_wd.side = side_r;
      slot_wd.off  = off_r;
      lvl_wd.cnt   = new_cnt;
      lvl_wd.sum   = new_sum;
      lvl_wd.head  = new_head;
      lvl_wd.tail  = new_tail;
      slot_we      = cmd.lvl_upd && (cmd.mode != MODE_FILL);
      lvl_we       = cmd.lvl_upd && (cmd.mode != MODE_FILL);
    end
  end

  assign slot_raddr = cmd.rd_front ? front_slot_r : ptr_r;

  obac_ram #(.W($bits(slot_word_t)), .D(MAX_ORDERS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wd),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  obac_ram #(.W($bits(level_word_t)), .D(LEVELS)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wd),
    .raddr (lvl_r),
    .rdata (lvl_rdata)
  );

  obac_ram #(.W(SLOT_W), .D(MAX_ORDERS)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_addr),
    .wdata (pv_data),
    .raddr (tgt_r),
    .rdata (prv_q)
  );

  obac_ram #(.W(SLOT_W), .D(MAX_ORDERS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_addr),
    .wdata (nx_data),
    .raddr (tgt_r),
    .rdata (nxt_q)
  );

  always_comb begin
    stat.clr_last   = (clr_r == CLR_W'(CLR_DEPTH - 1));
    stat.kind       = kind_r;
    stat.oor        = diff[PRICE_W] || (diff[PRICE_W-1:0] >= PRICE_W'(PRICE_LEVELS));
    stat.used       = (slot_q.st == SLOT_USED);
    stat.empty      = (slot_q.st == SLOT_EMPTY);
    stat.key_match  = (slot_q.key == id_r);
    stat.probe_last = (pcnt_r == PCNT_W'(PROBE_LIMIT - 1));
    stat.have_free  = have_free_r;
    stat.new_cnt_nz = (new_cnt != '0);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_result_id       = o_id_r;
  assign out_result_price    = o_price_r;
  assign out_result_side     = o_side_r;
  assign out_result_quantity = o_qty_r;
  assign out_level_orders    = o_cnt_r;
  assign out_level_total     = o_sum_r;
  assign out_front_id        = o_front_r;
endmodule

/* hw/rtl/order_book_add_cancel_core.sv */
// top level of the limit order book with add and cancel by id
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  in_ch   | in  | kind, order_id, price, side, quantity
//  out_ch  | out | status, result_id/price/side/quantity, level summary, front_id
//  cfg_    | in  | price_base write (cfg_we, cfg_wdata), no read-back
//
// one order at a time: the beat is taken and the id hashed, then 1 to 16 directory
// slots are probed, each by a registered slot read and then a compare, then the
// level is read and relinked, the oldest order is looked up when the level is not
// empty, and the result is loaded; a price out of range skips probing, level and
// lookup, an unknown id skips level and lookup
// after reset a clearing pass empties the level and slot memories;
// no beat is taken until it ends, configuration writes are taken throughout
// a finished result waits in the output register while the next beat is taken;
// only a second result with the first still untaken holds the sequencer
module order_book_add_cancel_core (
  input  logic                         clk,
  input  logic                         rst_n,
  obac_in_if.sink                      in_ch,
  obac_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [obac_pkg::PRICE_W-1:0] cfg_wdata
);
  import obac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: clearing pass, hash wait, probe loop, relink, front lookup
  obac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories and working registers, plus the output register
  obac_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_kind             (in_ch.kind),
    .in_order_id         (in_ch.order_id),
    .in_price            (in_ch.price),
    .in_side             (in_ch.side),
    .in_quantity         (in_ch.quantity),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_status          (out_ch.status),
    .out_result_id       (out_ch.result_id),
    .out_result_price    (out_ch.result_price),
    .out_result_side     (out_ch.result_side),
    .out_result_quantity (out_ch.result_quantity),
    .out_level_orders    (out_ch.level_orders),
    .out_level_total     (out_ch.level_total),
    .out_front_id        (out_ch.front_id)
  );

`ifndef SYNTHESIS
  // one order in flight: no second beat straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("beat accepted while previous order still in work");

  // a result never overwrites one still waiting on the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result register loaded while holding an untaken beat");

  // no beat taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ch.ready)
    else $error("input ready during memory clearing");
`endif
endmodule

/* tb/sv/tb.sv */
// self-checking testbench of the order book add/cancel core
module tb;
  import obac_pkg::*;

  // expected contents of one result beat
  typedef struct {
    result_st_t        status;
    logic [ID_W-1:0]   id;
    logic [PRICE_W-1:0] price;
    logic              side;
    logic [QTY_W-1:0]  qty;
    logic [CNT_W-1:0]  orders;
    logic [SUM_W-1:0]  total;
    logic [ID_W-1:0]   front;
  } book_reply_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PRICE_W-1:0] cfg_wdata;

  obac_in_if  in_ch ();
  obac_out_if out_ch ();

  order_book_add_cancel_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // book image kept alongside the core
  logic [PRICE_W-1:0] bk_base;
  slot_st_t           bk_state [MAX_ORDERS];
  logic [ID_W-1:0]    bk_key   [MAX_ORDERS];
  logic [QTY_W-1:0]   bk_qty   [MAX_ORDERS];
  logic               bk_side  [MAX_ORDERS];
  int unsigned        bk_off   [MAX_ORDERS];
  int unsigned        bk_prev  [MAX_ORDERS];
  int unsigned        bk_next  [MAX_ORDERS];
  int unsigned        lv_head  [LEVELS];
  int unsigned        lv_tail  [LEVELS];
  int unsigned        lv_cnt   [LEVELS];
  longint unsigned    lv_sum   [LEVELS];

  book_reply_t        pending_replies [$];
  logic [ID_W-1:0]    resting_ids [$];
  int                 failures;
  int                 beats_in;
  int                 beats_out;
  int                 n_cancelled;
  int                 n_rejected;
  int                 cycle_count;
  bit                 calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit: covers the clearing pass and all beats, with margin
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("[order_book_add_cancel_core] ERROR");
      $finish;
    end
  end

  function automatic int unsigned home_of(logic [ID_W-1:0] id);
    logic [63:0] h;
    h = id * GOLDEN;
    h = h ^ (h >> 32);
    return h[SLOT_W-1:0];
  endfunction

  function automatic void level_view(int unsigned lvl, ref book_reply_t r);
    r.orders = CNT_W'(lv_cnt[lvl]);
    r.total  = SUM_W'(lv_sum[lvl]);
    r.front  = (lv_cnt[lvl] != 0) ? bk_key[lv_head[lvl]] : '0;
  endfunction

  // reply of the book to one order message, updating the book image
  function automatic book_reply_t book_apply(logic kind, logic [ID_W-1:0] id,
                                             logic [PRICE_W-1:0] price, logic side,
                                             logic [QTY_W-1:0] qty);
    book_reply_t r;
    int unsigned s, free_s, off, lvl, t, prv, nxt, hd, tl;
    bit have_free, found;
    r = '{status: ST_ADDED, id: id, price: '0, side: 1'b0, qty: '0,
          orders: '0, total: '0, front: '0};
    s = home_of(id);
    have_free = 0;
    found = 0;
    free_s = 0;
    if (kind == 1'b0) begin
      r.price = price;
      r.side  = side;
      r.qty   = qty;
      if (price < bk_base || longint'(price - bk_base) >= PRICE_LEVELS) begin
        r.status = ST_RANGE;
        return r;
      end
      off = price - bk_base;
      lvl = side * PRICE_LEVELS + off;
      for (int i = 0; i < PROBE_LIMIT; i++) begin
        if (bk_state[s] == SLOT_USED) begin
          if (bk_key[s] == id) begin
            r.status = ST_DUPLICATE;
            level_view(lvl, r);
            return r;
          end
        end else begin
          if (!have_free) begin
            have_free = 1;
            free_s = s;
          end
          if (bk_state[s] == SLOT_EMPTY) break;
        end
        s = (s + 1) % MAX_ORDERS;
      end
      if (!have_free) begin
        r.status = ST_FULL;
        level_view(lvl, r);
        return r;
      end
      s = free_s;
      bk_state[s] = SLOT_USED;
      bk_key[s]   = id;
      bk_qty[s]   = qty;
      bk_side[s]  = side;
      bk_off[s]   = off;
      if (lv_cnt[lvl] == 0) begin
        bk_prev[s] = s;
        bk_next[s] = s;
        lv_head[lvl] = s;
        lv_tail[lvl] = s;
      end else begin
        t = lv_tail[lvl];
        bk_next[t] = s;
        bk_prev[s] = t;
        bk_next[s] = s;
        lv_tail[lvl] = s;
      end
      lv_cnt[lvl]++;
      lv_sum[lvl] += qty;
      r.status = ST_ADDED;
      level_view(lvl, r);
      return r;
    end
    // cancel: probe until an empty slot or the id
    for (int i = 0; i < PROBE_LIMIT; i++) begin
      if (bk_state[s] == SLOT_EMPTY) break;
      if (bk_state[s] == SLOT_USED && bk_key[s] == id) begin
        found = 1;
        break;
      end
      s = (s + 1) % MAX_ORDERS;
    end
    if (!found) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    off = bk_off[s];
    lvl = bk_side[s] * PRICE_LEVELS + off;
    prv = bk_prev[s];
    nxt = bk_next[s];
    hd  = lv_head[lvl];
    tl  = lv_tail[lvl];
    if (lv_cnt[lvl] > 1) begin
      if (s == hd) hd = nxt;
      else bk_next[prv] = nxt;
      if (s == tl) tl = prv;
      else bk_prev[nxt] = prv;
      lv_head[lvl] = hd;
      lv_tail[lvl] = tl;
    end
    if (lv_cnt[lvl] > 0) lv_cnt[lvl]--;
    lv_sum[lvl] = (lv_sum[lvl] >= bk_qty[s]) ? lv_sum[lvl] - bk_qty[s] : 0;
    bk_state[s] = SLOT_FREED;
    r.status = ST_CANCELLED;
    r.price  = bk_base + off;
    r.side   = bk_side[s];
    r.qty    = bk_qty[s];
    level_view(lvl, r);
    return r;
  endfunction

  // one order beat: optional gap, hold valid until taken, then predict
  task automatic send_order(logic kind, logic [ID_W-1:0] id, logic [PRICE_W-1:0] price,
                            logic side, logic [QTY_W-1:0] qty);
    int gap;
    book_reply_t r;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.order_id <= id;
    in_ch.price    <= price;
    in_ch.side     <= side;
    in_ch.quantity <= qty;
    do @(posedge clk); while (!in_ch.ready);
    beats_in++;
    r = book_apply(kind, id, price, side, qty);
    pending_replies.insert(pending_replies.size(), r);
    case (r.status)
      ST_ADDED: resting_ids.insert(resting_ids.size(), id);
      ST_CANCELLED: begin
        n_cancelled++;
        foreach (resting_ids[i]) if (resting_ids[i] == id) begin
          resting_ids.delete(i);
          break;
        end
      end
      default: n_rejected++;
    endcase
  endtask

  task automatic add_order(logic [ID_W-1:0] id, logic [PRICE_W-1:0] price, logic side,
                           logic [QTY_W-1:0] qty);
    send_order(1'b0, id, price, side, qty);
  endtask

  // ignored fields of a cancel carry noise
  task automatic cancel_order(logic [ID_W-1:0] id);
    send_order(1'b1, id, $urandom, $urandom_range(0, 1), $urandom);
  endtask

  // drop valid and wait for every outstanding reply
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(logic [PRICE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bk_base = v;
  endtask

  function automatic logic [ID_W-1:0] fresh_id();
    return {$urandom, $urandom};
  endfunction

  // result side: random stall per beat, compare with the oldest expectation
  initial begin
    book_reply_t e;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      beats_out++;
      if (pending_replies.size() == 0) begin
        $error("result beat with nothing expected, status %0d", out_ch.status);
        failures++;
      end else begin
        e = pending_replies.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status); failures++;
        end
        if (out_ch.result_id !== e.id) begin
          $error("result_id exp %h got %h", e.id, out_ch.result_id); failures++;
        end
        if (out_ch.result_price !== e.price) begin
          $error("result_price exp %h got %h", e.price, out_ch.result_price); failures++;
        end
        if (out_ch.result_side !== e.side) begin
          $error("result_side exp %b got %b", e.side, out_ch.result_side); failures++;
        end
        if (out_ch.result_quantity !== e.qty) begin
          $error("result_quantity exp %h got %h", e.qty, out_ch.result_quantity);
          failures++;
        end
        if (out_ch.level_orders !== e.orders) begin
          $error("level_orders exp %0d got %0d", e.orders, out_ch.level_orders); failures++;
        end
        if (out_ch.level_total !== e.total) begin
          $error("level_total exp %h got %h", e.total, out_ch.level_total); failures++;
        end
        if (out_ch.front_id !== e.front) begin
          $error("front_id exp %h got %h", e.front, out_ch.front_id); failures++;
        end
      end
    end
  end

  // price edges, id and quantity extremes, rejects and fifo unlinking
  task automatic test_edges;
    logic [ID_W-1:0] a, b, c;
    set_base(32'd1000);
    add_order('0, 32'd1000, 1'b0, '0);
    add_order('1, 32'd5095, 1'b1, '1);
    add_order(fresh_id(), 32'd999, 1'b0, 32'd7);
    add_order(fresh_id(), 32'd5096, 1'b1, 32'd7);
    add_order('1, 32'd1000, 1'b0, 32'd3);
    cancel_order(64'h1234_5678_9abc_def0);
    a = fresh_id(); b = fresh_id(); c = fresh_id();
    add_order(a, 32'd1003, 1'b1, 32'd10);
    add_order(b, 32'd1003, 1'b1, 32'd20);
    add_order(c, 32'd1003, 1'b1, 32'd30);
    cancel_order(b);
    cancel_order(a);
    cancel_order(c);
    cancel_order(c);
    cancel_order('0);
    cancel_order('1);
  endtask

  // orders keep their offset when the base moves
  task automatic test_rebase;
    logic [ID_W-1:0] a;
    a = fresh_id();
    add_order(a, 32'd1017, 1'b0, 32'd55);
    set_base(32'd50);
    cancel_order(a);
    set_base(32'd1000);
  endtask

  // sixteen ids sharing one home slot fill the probe window
  task automatic test_probe_window;
    logic [ID_W-1:0] same_home [$];
    logic [ID_W-1:0] id;
    int unsigned h;
    bit busy;
    do begin
      h = $urandom_range(0, MAX_ORDERS - 1);
      busy = 0;
      for (int i = 0; i < PROBE_LIMIT; i++)
        if (bk_state[(h + i) % MAX_ORDERS] == SLOT_USED) busy = 1;
    end while (busy);
    while (same_home.size() < PROBE_LIMIT + 2) begin
      id = fresh_id();
      if (home_of(id) == h) same_home.insert(same_home.size(), id);
    end
    for (int i = 0; i <= PROBE_LIMIT; i++)
      add_order(same_home[i], bk_base + i, i % 2, $urandom);
    add_order(same_home[PROBE_LIMIT - 1], bk_base, 1'b0, 32'd1);
    cancel_order(same_home[PROBE_LIMIT + 1]);
    cancel_order(same_home[5]);
    add_order(same_home[PROBE_LIMIT], bk_base + 2, 1'b1, 32'd9);
    cancel_order(same_home[PROBE_LIMIT + 1]);
    for (int i = 0; i <= PROBE_LIMIT; i++) cancel_order(same_home[i]);
  endtask

  // mostly adds near the base and cancels of resting orders, some noise
  task automatic test_random(int n, logic [PRICE_W-1:0] base, bit quiet);
    int r;
    logic [QTY_W-1:0] q;
    set_base(base);
    calm = quiet;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
      if (resting_ids.size() > 500 && r < 60) r = 70;
      if (r < 45)
        add_order(fresh_id(), bk_base + (($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, PRICE_LEVELS - 1) : $urandom_range(0, 7)),
                  $urandom_range(0, 1), q);
      else if (r < 55)
        add_order(fresh_id(), ($urandom_range(0, 1) ? $urandom : bk_base - 1),
                  $urandom_range(0, 1), q);
      else if (r < 60 && resting_ids.size() > 0)
        add_order(resting_ids[$urandom_range(0, resting_ids.size() - 1)],
                  bk_base + $urandom_range(0, 7), $urandom_range(0, 1), q);
      else if (r < 92 && resting_ids.size() > 0)
        cancel_order(resting_ids[$urandom_range(0, resting_ids.size() - 1)]);
      else
        cancel_order(fresh_id());
    end
    calm = 0;
  endtask

  initial begin
    failures = 0; beats_in = 0; beats_out = 0; n_cancelled = 0; n_rejected = 0;
    calm = 0;
    bk_base = '0;
    foreach (bk_state[i]) bk_state[i] = SLOT_EMPTY;
    foreach (lv_cnt[i]) begin
      lv_cnt[i] = 0;
      lv_sum[i] = 0;
    end
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= 1'b0;
    in_ch.order_id <= '0;
    in_ch.price    <= '0;
    in_ch.side     <= 1'b0;
    in_ch.quantity <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges();
    test_rebase();
    test_probe_window();
    test_random(170, 32'd0, 1'b0);
    test_random(100, 32'hFFFF_F000, 1'b1);
    test_random(80, 32'hFFFF_FFFF, 1'b0);
    test_random(170, $urandom, 1'b0);
    test_random(180, 32'd4242, 1'b0);

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d order beats, %0d results: %0d cancels, %0d rejects, %0d resting",
             beats_in, beats_out, n_cancelled, n_rejected, resting_ids.size());
    $display("bases swept from zero to all ones, probe window filled and reused");
    if (failures == 0 && pending_replies.size() == 0) begin
      $display("[order_book_add_cancel_core] OK");
    end else begin
      $display("[order_book_add_cancel_core] ERROR");
    end
    $finish;
  end

endmodule
